### hdl/hafd_pkg.sv
// Shared constants, types and functions of the hex ASCII frame deframer.
// No dependencies; hafd_rx and the top level import this package, hafd_ram does not.
package hafd_pkg;

	localparam int PAYLOAD_BYTES_DEF = 36;
	localparam int FRAME_LEN_DEF     = 77;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 1'b1;

	localparam logic [7:0] START_CODE_RST = 8'h02;
	localparam logic [7:0] END_CODE_RST   = 8'h03;

	localparam logic [7:0] MSG_KIND3 = 8'h33;
	localparam logic [7:0] MSG_KIND4 = 8'h43;
	localparam logic [7:0] MSG_KIND5 = 8'h53;
	localparam logic [7:0] MSG_OTHER = 8'h11;

	localparam int OUT_DATA_W = 32;

	// One result waiting in the output queue
	typedef struct packed {
		logic [7:0] payload_byte;
		logic [5:0] payload_index;
		logic       last;
	} out_item_t;

	function automatic logic [7:0] map_code(input logic [7:0] v);
		logic [7:0] r;
		case (v)
			8'd3:    r = MSG_KIND3;
			8'd4:    r = MSG_KIND4;
			8'd5:    r = MSG_KIND5;
			8'd6:    r = MSG_KIND5;
			default: r = MSG_OTHER;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_value(input logic [7:0] c);
		logic [7:0] r;
		if (c < 8'h40) begin
			r = c - 8'h30;
		end else begin
			r = c - 8'h37;
		end
		return r;
	endfunction

endpackage

### hdl/hafd_ram.sv
// Payload store of the deframer: one write port, one read port, read data
// registered. Depends on nothing but its parameters.
module hafd_ram #(
	parameter int DEPTH = 36,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/hafd_rx.sv
// Frame parser: counts frame bytes, decodes hex pairs into payload store
// writes, holds the frame tag and message code. Uses hafd_pkg.
module hafd_rx #(
	parameter int PAYLOAD_BYTES = 36,
	parameter int FRAME_LEN     = 77,
	parameter int AW            = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic [7:0]    start_code,
	input  logic [7:0]    end_code,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic          drain_start,
	output logic [7:0]    frame_tag,
	output logic [7:0]    message_code
);
	import hafd_pkg::*;

	localparam int CW_F = $clog2(FRAME_LEN + 2);
	localparam int CW_P = $clog2(2 * PAYLOAD_BYTES + 2);
	localparam int CW   = (CW_F > CW_P) ? CW_F : CW_P;
	localparam logic [AW-1:0] CODE_ADDR = AW'((PAYLOAD_BYTES > 5) ? 5 : 4);

	logic          in_frame_q;
	logic [CW-1:0] cnt_q;
	logic [3:0]    hi_q;
	logic [7:0]    tag_q;
	logic [7:0]    code_q;

	logic          is_start, is_end, infr, hex_pos, good;
	logic [CW-1:0] pos, pos_next, cnt_upd, h;
	logic [7:0]    v;

	always_comb begin
		is_start = (in_byte == start_code);
		is_end   = (in_byte == end_code);
		infr     = is_start | in_frame_q;
		pos      = is_start ? '0 : cnt_q;
		// saturate one past the frame length so an overrun never matches
		pos_next = (int'(pos) < FRAME_LEN + 1) ? pos + CW'(1) : pos;
		cnt_upd  = infr ? pos_next : cnt_q;
		good     = is_end && (cnt_upd == CW'(FRAME_LEN));
		hex_pos  = infr && (int'(pos) >= 2) && (int'(pos) < 2 * PAYLOAD_BYTES + 2);
		h        = pos - CW'(2);
		v        = hex_value(in_byte);
		wr_en    = in_valid & hex_pos & h[0];
		wr_addr  = h[AW:1];
		wr_data  = {hi_q, 4'h0} | v;
		drain_start = in_valid & good;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			hi_q       <= '0;
			tag_q      <= '0;
		end else if (in_valid) begin
			in_frame_q <= is_end ? 1'b0 : infr;
			cnt_q      <= good ? '0 : cnt_upd;
			if (infr && pos == CW'(1)) begin
				tag_q <= in_byte;
			end
			if (hex_pos && !h[0]) begin
				hi_q <= v[3:0];
			end
		end
	end

	// shadow of the code-bearing payload entry, kept in step with its writes
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == CODE_ADDR) begin
			code_q <= map_code(wr_data);
		end
	end

	assign frame_tag    = tag_q;
	assign message_code = (PAYLOAD_BYTES > 4) ? code_q : MSG_OTHER;

endmodule

### hdl/hex_ascii_frame_deframer.sv
// Top level of the hex ASCII frame deframer: configuration registers, drain
// sequencer and output queue. Uses hafd_pkg, hafd_rx and hafd_ram.
//
//  channel   | direction | payload                                   | accept
//  s_axis    | in        | tdata[7:0] rx_byte                        | tvalid & tready
//  m_axis    | out       | tdata byte/index/tag/code, tlast = last   | tvalid & tready
//  cfg       | in        | cfg_index selects register, cfg_data      | cfg_we
//
// One received item is taken per cycle while no frame is being emitted.
// A good end code starts a drain of PAYLOAD_BYTES results, one per cycle when
// m_axis_tready stays high; the payload store's one read port paces it, with
// its registered read data covered by a two-deep output queue.
// s_axis_tready stays low from the good end code until the last result goes.
// Reset clears the frame count, flags and queue; the payload store has no reset.
module hex_ascii_frame_deframer #(
	parameter int PAYLOAD_BYTES = hafd_pkg::PAYLOAD_BYTES_DEF,
	parameter int FRAME_LEN     = hafd_pkg::FRAME_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] payload_byte, [13:8] payload_index, [21:14] frame_tag,
	// [29:22] message_code, [31:30] zero
	output logic [hafd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast,   // last
	input  logic                           cfg_we,
	input  logic [hafd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import hafd_pkg::*;

	localparam int AW = $clog2(PAYLOAD_BYTES);

	logic [7:0] start_code_q, end_code_q;

	// configuration writes; the user must issue them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= START_CODE_RST;
			end_code_q   <= END_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_CODE: start_code_q <= cfg_data;
				CFG_END_CODE:   end_code_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic          busy_q;
	logic          in_acc;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          drain_start;
	logic [7:0]    frame_tag, message_code;

	assign s_axis_tready = ~busy_q;
	assign in_acc        = s_axis_tvalid & ~busy_q;

	hafd_rx #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.FRAME_LEN    (FRAME_LEN),
		.AW           (AW)
	) u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_acc),
		.in_byte     (s_axis_tdata),
		.start_code  (start_code_q),
		.end_code    (end_code_q),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.drain_start (drain_start),
		.frame_tag   (frame_tag),
		.message_code(message_code)
	);

	// Drain sequencer: walk j = 0..PAYLOAD_BYTES-1, read the swapped entry
	logic          drain_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] j_swap, rd_addr;
	logic          issue, j_last;
	logic [7:0]    rd_data;

	logic          rd_v_s1;
	logic [AW-1:0] idx_s1;
	logic          last_s1;

	logic [1:0]    occ_q;
	out_item_t     head_q, skid_q, new_item;
	logic          pop;
	logic [2:0]    credit;

	always_comb begin
		j_swap  = j_q ^ AW'(1);
		// an unpaired final byte stays in place
		rd_addr = (int'(j_swap) < PAYLOAD_BYTES) ? j_swap : j_q;
		j_last  = (j_q == AW'(PAYLOAD_BYTES - 1));
		pop     = m_axis_tvalid & m_axis_tready;
		credit  = {1'b0, occ_q} + {2'b00, rd_v_s1} - {2'b00, pop};
		// issue only when the queue will have room for the returning read
		issue   = drain_q && (credit <= 3'd1);
		new_item.payload_byte  = rd_data;
		new_item.payload_index = 6'(idx_s1);
		new_item.last          = last_s1;
	end

	hafd_ram #(
		.DEPTH(PAYLOAD_BYTES),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (issue),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			drain_q <= 1'b0;
			j_q     <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			// hold input off from the good end code until the last item leaves
			if (drain_start) begin
				busy_q  <= 1'b1;
				drain_q <= 1'b1;
				j_q     <= '0;
			end else begin
				if (pop && head_q.last) begin
					busy_q <= 1'b0;
				end
				if (issue) begin
					j_q <= j_q + AW'(1);
					if (j_last) begin
						drain_q <= 1'b0;
					end
				end
			end
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= j_q;
			last_s1 <= j_last;
		end
	end

	// Two-deep output queue: head drives the port, skid catches a read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + {1'b0, rd_v_s1} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1 && pop) begin
			if (occ_q == 2'd2) begin
				head_q <= skid_q;
				skid_q <= new_item;
			end else begin
				head_q <= new_item;
			end
		end else if (rd_v_s1) begin
			if (occ_q == 2'd0) begin
				head_q <= new_item;
			end else begin
				skid_q <= new_item;
			end
		end else if (pop) begin
			head_q <= skid_q;
		end
	end

	assign m_axis_tvalid = (occ_q != 2'd0);
	assign m_axis_tlast  = head_q.last;
	assign m_axis_tdata  = {2'b00, message_code, frame_tag,
		head_q.payload_index, head_q.payload_byte};

endmodule
